@@ rtl/core/pfc_pkg.sv @@
`default_nettype none

package pfc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 18;
    localparam int RECIP_W  = 19;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int RECIP_SH = 28;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 3;
    localparam int DEPTH_W  = 6;
    localparam int INDEX_W  = 2;

    localparam logic [INDEX_W-1:0] CFG_COLOR_INPUT = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_DEPTH_BITS  = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_YUV_OUTPUT  = 2'd2;
    localparam logic [INDEX_W-1:0] CFG_YUV_ORDER   = 2'd3;

    localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 6'd24;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;

    localparam logic [SUM_W-1:0] K_YR   = 18'd299;
    localparam logic [SUM_W-1:0] K_YG   = 18'd587;
    localparam logic [SUM_W-1:0] K_YB   = 18'd114;
    localparam logic [SUM_W-1:0] K_BIAS = 18'd128000;
    localparam logic [SUM_W-1:0] K_UR   = 18'd169;
    localparam logic [SUM_W-1:0] K_UG   = 18'd331;
    localparam logic [SUM_W-1:0] K_HALF = 18'd500;
    localparam logic [SUM_W-1:0] K_VG   = 18'd419;
    localparam logic [SUM_W-1:0] K_VB   = 18'd81;

    // ceil(2^28 / 1000): exact floor division for numerators below 2^18
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

    localparam logic [SAMPLE_W-1:0] Y_MIN  = 8'd16;
    localparam logic [SAMPLE_W-1:0] Y_MAX  = 8'd235;
    localparam logic [SAMPLE_W-1:0] UV_MIN = 8'd16;
    localparam logic [SAMPLE_W-1:0] UV_MAX = 8'd240;

    localparam logic [COUNT_W-1:0] COUNT_2 = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_3 = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_4 = 3'd4;

    typedef struct packed {
        logic                color_input;
        logic [DEPTH_W-1:0]  depth_bits;
        logic                yuv_output;
        logic                yuv_order;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] r;
        logic [SAMPLE_W-1:0] g;
        logic [SAMPLE_W-1:0] b;
        logic                le;
    } pix_t;

    typedef struct packed {
        logic [SUM_W-1:0] y;
        logic [SUM_W-1:0] u;
        logic [SUM_W-1:0] v;
        pix_t             pix;
    } sum_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
        pix_t                pix;
    } quo_t;

endpackage

`default_nettype wire

@@ rtl/core/pixel_format_converter.sv @@
`default_nettype none

// Channel   Direction  Content
// s_axis    in         tdata: red, green, blue (low to high); tlast: line end
// m_axis    out        tdata: pixel word, byte count (low to high); tlast: line end
// cfg       in         write enable, register index, write data
//
// Four register stages: input capture, weighted sums, divide by 1000 through a
// reciprocal multiply, then clamp and pack. One pixel per clock while m_axis is
// not stalled. Reset clears all valid bits and loads the register defaults.
// A stall on m_axis holds each full stage; bubbles are squeezed out upstream.
// A pixel taken with an invalid depth setting is dropped at input capture.

module pixel_format_converter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red_sample, green_sample, blue_sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // pixel_word, byte_count, zero pad
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);

    pfc_pkg::cfg_t                 cfg_reg;
    logic                          in_valid_reg;
    pfc_pkg::pix_t                 in_data_reg;
    pfc_pkg::pix_t                 in_data_next;
    logic                          in_ready;
    logic                          depth_ok;
    logic                          sum_ready;
    logic                          sum_valid;
    pfc_pkg::sum_t                 sum_data;
    logic                          div_ready;
    logic                          div_valid;
    pfc_pkg::quo_t                 div_data;
    logic                          pack_ready;
    logic [pfc_pkg::WORD_W-1:0]    out_word;
    logic [pfc_pkg::COUNT_W-1:0]   out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_input <= 1'b1;
            cfg_reg.depth_bits  <= pfc_pkg::DEPTH_24;
            cfg_reg.yuv_output  <= 1'b0;
            cfg_reg.yuv_order   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfc_pkg::CFG_COLOR_INPUT: cfg_reg.color_input <= cfg_data[0];
                pfc_pkg::CFG_DEPTH_BITS:  cfg_reg.depth_bits  <= cfg_data;
                pfc_pkg::CFG_YUV_OUTPUT:  cfg_reg.yuv_output  <= cfg_data[0];
                pfc_pkg::CFG_YUV_ORDER:   cfg_reg.yuv_order   <= cfg_data[0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign depth_ok = (cfg_reg.depth_bits == pfc_pkg::DEPTH_16)
                   || (cfg_reg.depth_bits == pfc_pkg::DEPTH_24)
                   || (cfg_reg.depth_bits == pfc_pkg::DEPTH_32);

    assign in_ready      = !in_valid_reg || sum_ready;
    assign s_axis_tready = in_ready;

    always_comb
    begin
        in_data_next.r  = s_axis_tdata[7:0];
        in_data_next.g  = cfg_reg.color_input ? s_axis_tdata[15:8]  : s_axis_tdata[7:0];
        in_data_next.b  = cfg_reg.color_input ? s_axis_tdata[23:16] : s_axis_tdata[7:0];
        in_data_next.le = s_axis_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_axis_tvalid && depth_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            in_data_reg <= in_data_next;
        end
    end

    pfc_sum u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (sum_ready),
        .in_data   (in_data_reg),
        .out_valid (sum_valid),
        .out_ready (div_ready),
        .out_data  (sum_data)
    );

    pfc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (div_ready),
        .in_data   (sum_data),
        .out_valid (div_valid),
        .out_ready (pack_ready),
        .out_data  (div_data)
    );

    pfc_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (div_valid),
        .in_ready  (pack_ready),
        .in_data   (div_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_count, out_word};

endmodule

`default_nettype wire

@@ rtl/core/pfc_sum.sv @@
`default_nettype none

module pfc_sum
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  pfc_pkg::pix_t      in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pfc_pkg::sum_t      out_data
);

    logic                  valid_reg;
    pfc_pkg::sum_t         data_reg;
    pfc_pkg::sum_t         data_next;
    logic [pfc_pkg::SUM_W-1:0] r_ext;
    logic [pfc_pkg::SUM_W-1:0] g_ext;
    logic [pfc_pkg::SUM_W-1:0] b_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        r_ext = pfc_pkg::SUM_W'(in_data.r);
        g_ext = pfc_pkg::SUM_W'(in_data.g);
        b_ext = pfc_pkg::SUM_W'(in_data.b);
        // U and V numerators never go below 500, so modulo arithmetic is exact
        data_next.y   = pfc_pkg::K_YR * r_ext + pfc_pkg::K_YG * g_ext
                      + pfc_pkg::K_YB * b_ext;
        data_next.u   = pfc_pkg::K_BIAS + pfc_pkg::K_HALF * b_ext
                      - pfc_pkg::K_UR * r_ext - pfc_pkg::K_UG * g_ext;
        data_next.v   = pfc_pkg::K_BIAS + pfc_pkg::K_HALF * r_ext
                      - pfc_pkg::K_VG * g_ext - pfc_pkg::K_VB * b_ext;
        data_next.pix = in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pfc_div.sv @@
`default_nettype none

module pfc_div
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  pfc_pkg::sum_t      in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pfc_pkg::quo_t      out_data
);

    logic                       valid_reg;
    pfc_pkg::quo_t              data_reg;
    pfc_pkg::quo_t              data_next;
    logic [pfc_pkg::PROD_W-1:0] y_prod;
    logic [pfc_pkg::PROD_W-1:0] u_prod;
    logic [pfc_pkg::PROD_W-1:0] v_prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        y_prod = pfc_pkg::PROD_W'(in_data.y) * pfc_pkg::PROD_W'(pfc_pkg::RECIP_1000);
        u_prod = pfc_pkg::PROD_W'(in_data.u) * pfc_pkg::PROD_W'(pfc_pkg::RECIP_1000);
        v_prod = pfc_pkg::PROD_W'(in_data.v) * pfc_pkg::PROD_W'(pfc_pkg::RECIP_1000);
        data_next.y   = y_prod[pfc_pkg::RECIP_SH +: pfc_pkg::SAMPLE_W];
        data_next.u   = u_prod[pfc_pkg::RECIP_SH +: pfc_pkg::SAMPLE_W];
        data_next.v   = v_prod[pfc_pkg::RECIP_SH +: pfc_pkg::SAMPLE_W];
        data_next.pix = in_data.pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pfc_pack.sv @@
`default_nettype none

module pfc_pack
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  pfc_pkg::cfg_t                      cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  pfc_pkg::quo_t                      in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pfc_pkg::WORD_W-1:0]         out_word,
    output logic [pfc_pkg::COUNT_W-1:0]        out_count,
    output logic                               out_last
);

    logic                          valid_reg;
    logic [pfc_pkg::WORD_W-1:0]    word_reg;
    logic [pfc_pkg::WORD_W-1:0]    word_next;
    logic [pfc_pkg::COUNT_W-1:0]   count_reg;
    logic [pfc_pkg::COUNT_W-1:0]   count_next;
    logic                          last_reg;
    logic [pfc_pkg::SAMPLE_W-1:0]  y_c;
    logic [pfc_pkg::SAMPLE_W-1:0]  u_c;
    logic [pfc_pkg::SAMPLE_W-1:0]  v_c;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        priority if (in_data.y < pfc_pkg::Y_MIN)      y_c = pfc_pkg::Y_MIN;
        else if (in_data.y > pfc_pkg::Y_MAX)          y_c = pfc_pkg::Y_MAX;
        else                                          y_c = in_data.y;

        priority if (in_data.u < pfc_pkg::UV_MIN)     u_c = pfc_pkg::UV_MIN;
        else if (in_data.u > pfc_pkg::UV_MAX)         u_c = pfc_pkg::UV_MAX;
        else                                          u_c = in_data.u;

        priority if (in_data.v < pfc_pkg::UV_MIN)     v_c = pfc_pkg::UV_MIN;
        else if (in_data.v > pfc_pkg::UV_MAX)         v_c = pfc_pkg::UV_MAX;
        else                                          v_c = in_data.v;

        priority if (cfg.yuv_output)
        begin
            word_next  = cfg.yuv_order ? {v_c, y_c, u_c, y_c} : {y_c, v_c, y_c, u_c};
            count_next = pfc_pkg::COUNT_4;
        end
        else if (cfg.depth_bits == pfc_pkg::DEPTH_16)
        begin
            word_next  = {16'd0, in_data.pix.r[7:3], in_data.pix.g[7:2], in_data.pix.b[7:3]};
            count_next = pfc_pkg::COUNT_2;
        end
        else
        begin
            word_next  = {8'd0, in_data.pix.r, in_data.pix.g, in_data.pix.b};
            count_next = (cfg.depth_bits == pfc_pkg::DEPTH_32) ? pfc_pkg::COUNT_4
                                                               : pfc_pkg::COUNT_3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
            last_reg  <= in_data.pix.le;
        end
    end

endmodule

`default_nettype wire
